/* hdl/wes_pkg.sv */
// Package: shared constants and types for the wheel encoder speed tracker.
`timescale 1ns / 1ps
package wes_pkg;
  localparam int NUM_WHEELS_DEF   = 4;
  localparam int FILTER_DEPTH_DEF = 4;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int MS_PER_MIN       = 60000;
  localparam int MIN_DT_MS        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic       op;
    logic [1:0] wheel;
    logic signed [15:0] raw_count;
    logic [31:0] now_ms;
  } wes_in_t;

  typedef struct packed {
    logic [1:0] wheel_out;
    logic signed [31:0] total_count;
    logic signed [31:0] rpm_avg_q8;
    logic signed [47:0] distance_q8;
    logic [31:0] last_update_ms;
    logic        stale;
  } wes_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input, do state update part one
    logic rpm_start;  // start rpm division
    logic dist_start; // start distance division
    logic sum_step;   // accumulate one ring entry
    logic finish;     // commit rpm average / form result
  } wes_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_rpm;
    logic div_done;
    logic sum_last;
  } wes_sts_t;
endpackage

/* hdl/wes_if.sv */
// Valid/ready stream interface carrying a packed payload.
`timescale 1ns / 1ps
interface wes_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/wes_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wes_div #(
  parameter int NW = 64,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign diff  = trial - {1'b0, d};

  // Shift in one numerator bit and subtract when possible
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        if (!diff[DW]) rem <= diff;
        else rem <= trial;
        q   <= {q[NW-2:0], ~diff[DW]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

/* hdl/wes_ctrl.sv */
// Controller: sequences load, rpm division, ring averaging and distance division.
`timescale 1ns / 1ps
module wes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wes_pkg::wes_sts_t sts,
  output wes_pkg::wes_cmd_t cmd
);
  import wes_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RPM  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DIST = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.need_rpm) begin
          cmd.rpm_start = 1'b1;
          state_next = S_RPM;
        end else begin
          cmd.dist_start = 1'b1;
          state_next = S_DIST;
        end
      end
      S_RPM: if (sts.div_done) begin
        cmd.sum_step = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (sts.sum_last) begin
          cmd.finish = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.dist_start = 1'b1;
        state_next = S_DIST;
      end
      S_DIST: if (sts.div_done) state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOAD)) else $error("load missing");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

/* hdl/wes_dp.sv */
// Datapath: per-wheel state, rpm and distance arithmetic, ring average.
`timescale 1ns / 1ps
module wes_dp #(
  parameter int NUM_WHEELS   = wes_pkg::NUM_WHEELS_DEF,
  parameter int FILTER_DEPTH = wes_pkg::FILTER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wes_pkg::CFG_W-1:0]     cfg_data,
  input  wes_pkg::wes_in_t  in_data,
  input  wes_pkg::wes_cmd_t cmd,
  output wes_pkg::wes_sts_t sts,
  output wes_pkg::wes_out_t out_data
);
  import wes_pkg::*;

  localparam int PW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SUMW = 32 + PW + 1;
  localparam int WIW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  // Configuration registers
  logic [3:0]  enable_mask;
  logic [15:0] counts_per_rev, gear_ratio_q8, wheel_circ_q8, stale_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= 4'd3;
      counts_per_rev <= 16'd1440;
      gear_ratio_q8  <= 16'd256;
      wheel_circ_q8  <= 16'd5120;
      stale_limit    <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE:  enable_mask    <= cfg_data[3:0];
        REG_CPR:     counts_per_rev <= cfg_data;
        REG_GEAR:    gear_ratio_q8  <= cfg_data;
        REG_CIRC:    wheel_circ_q8  <= cfg_data;
        REG_TIMEOUT: stale_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-wheel state
  logic [15:0] prev_raw    [NUM_WHEELS];
  logic [31:0] total_acc   [NUM_WHEELS];
  logic [31:0] last_update [NUM_WHEELS];
  logic [31:0] rpm_filt    [NUM_WHEELS];
  logic [PW-1:0] hist_ptr  [NUM_WHEELS];
  logic [31:0] rpm_hist    [NUM_WHEELS][FILTER_DEPTH];

  // Captured transaction
  logic [1:0]  w;
  logic        valid_w, en_w, need_rpm;
  logic [31:0] now_r, tot_r;
  logic signed [16:0] delta_r;
  logic [PW-1:0] wp;
  logic [PW-1:0] sum_k;
  logic signed [SUMW-1:0] sum_acc;
  logic signed [31:0] rpm_r;
  logic sum_started;

  logic [15:0] cpr_eff;
  assign cpr_eff = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;

  logic [WIW-1:0] wi;
  assign wi = WIW'(in_data.wheel);
  logic in_rng;
  assign in_rng = (32'(in_data.wheel) < NUM_WHEELS);
  logic [WIW-1:0] wr;
  assign wr = WIW'(w);

  logic [15:0] d16;
  logic [31:0] dt_c;
  assign d16  = in_data.raw_count - prev_raw[wi];
  assign dt_c = in_data.now_ms - last_update[wi];

  // Divider operand selection (shared)
  logic [63:0] dnum;
  logic [47:0] dden;
  logic        dstart, dsign;
  logic [63:0] quo;
  logic        ddone;
  logic [47:0] mag_num;
  logic [31:0] dist_mag;
  logic signed [31:0] tot_s;
  assign tot_s = tot_r;
  assign dist_mag = tot_s[31] ? (~tot_r + 32'd1) : tot_r;

  // Multiply: |delta|*gear (32b) registered at load, then *60000 combinationally
  logic [31:0] dmag_g;
  logic [47:0] cpr_dt;
  assign mag_num = 48'(dmag_g) * 48'(MS_PER_MIN);

  logic rpm_go;
  always_comb begin
    dstart = cmd.rpm_start | cmd.dist_start;
    if (cmd.rpm_start) begin
      dnum = 64'(mag_num);
      dden = cpr_dt;
    end else begin
      dnum = 64'(dist_mag) * 64'(wheel_circ_q8);
      dden = 48'(cpr_eff);
    end
  end
  assign rpm_go = cmd.rpm_start;

  wes_div #(.NW(64), .DW(48)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(quo)
  );

  // Signed rpm with saturation
  logic signed [64:0] qs;
  logic signed [31:0] rpm_sat;
  always_comb begin
    qs = dsign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (qs > 65'sd2147483647) rpm_sat = 32'h7fffffff;
    else if (qs < -65'sd2147483648) rpm_sat = 32'h80000000;
    else rpm_sat = qs[31:0];
  end

  logic signed [SUMW-1:0] sum_q;
  logic signed [SUMW-1:0] sum_abs;
  logic [SUMW-1:0] avg_abs;
  assign sum_abs = sum_acc[SUMW-1] ? -sum_acc : sum_acc;
  assign avg_abs = $unsigned(sum_abs) / FILTER_DEPTH;
  assign sum_q = sum_acc[SUMW-1] ? -$signed(avg_abs) : $signed(avg_abs);

  logic [31:0] hist_rd;
  assign hist_rd = (sum_k == wp) ? rpm_r : rpm_hist[wr][sum_k];

  // Main sequencing of state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prev_raw[i] <= '0; total_acc[i] <= '0; last_update[i] <= '0;
        rpm_filt[i] <= '0; hist_ptr[i] <= '0;
        for (int j = 0; j < FILTER_DEPTH; j++) rpm_hist[i][j] <= '0;
      end
      need_rpm <= 1'b0;
    end else begin
      if (cmd.load) begin
        w <= in_data.wheel;
        valid_w <= in_rng;
        now_r <= in_data.now_ms;
        need_rpm <= 1'b0;
        en_w <= in_rng && enable_mask[in_data.wheel];
        delta_r <= $signed({d16[15], d16});
        if (in_rng && enable_mask[in_data.wheel]) begin
          if (in_data.op) begin
            total_acc[wi] <= '0;
            prev_raw[wi] <= '0;
            tot_r <= '0;
          end else begin
            total_acc[wi] <= total_acc[wi] + {{16{d16[15]}}, d16};
            tot_r <= total_acc[wi] + {{16{d16[15]}}, d16};
            prev_raw[wi] <= in_data.raw_count;
            need_rpm <= (dt_c >= 32'(MIN_DT_MS));
          end
        end else begin
          tot_r <= in_rng ? total_acc[wi] : 32'd0;
        end
      end
      if (cmd.load) begin
        dmag_g <= 32'(d16[15] ? 16'(-d16) : d16) * 32'(gear_ratio_q8);
        cpr_dt <= 48'(cpr_eff) * 48'(dt_c);
      end
      if (rpm_go) begin
        dsign <= delta_r[16];
        wp <= hist_ptr[wr];
      end
      if (cmd.dist_start) dsign <= tot_s[31];
      if (cmd.sum_step) begin
        if (sum_k == '0 && !sum_started) begin
          rpm_r <= rpm_sat;
        end
      end
      if (cmd.finish) begin
        rpm_hist[wr][wp] <= rpm_r;
        hist_ptr[wr] <= (32'(wp) == FILTER_DEPTH - 1) ? '0 : wp + 1'b1;
        rpm_filt[wr] <= sum_q[31:0];
        last_update[wr] <= now_r;
      end
    end
  end

  // Ring sum, one entry per cycle
  logic signed [31:0] add_v;
  assign add_v = sum_started ? $signed(hist_rd) : rpm_sat;
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_started <= 1'b0;
      sum_k <= '0;
    end else if (cmd.sum_step) begin
      if (!sum_started) begin
        sum_started <= 1'b1;
        sum_acc <= '0;
        sum_k <= '0;
      end else begin
        sum_acc <= sum_acc + SUMW'(add_v);
        sum_k <= (32'(sum_k) == FILTER_DEPTH - 1) ? '0 : sum_k + 1'b1;
      end
    end else if (cmd.finish) begin
      sum_started <= 1'b0;
    end
  end
  logic sum_done_f;
  always_ff @(posedge clk) begin
    if (rst) sum_done_f <= 1'b0;
    else if (cmd.sum_step && sum_started && 32'(sum_k) == FILTER_DEPTH - 1)
      sum_done_f <= 1'b1;
    else sum_done_f <= 1'b0;
  end

  assign sts.need_rpm = need_rpm;
  assign sts.div_done = ddone;
  assign sts.sum_last = sum_done_f;

  // Result assembly
  logic [47:0] dist_q;
  always_ff @(posedge clk) begin
    if (ddone) dist_q <= dsign ? 48'(-quo[47:0]) : quo[47:0];
  end
  logic [31:0] elapsed;
  assign elapsed = now_r - (valid_w ? last_update[wr] : 32'd0);
  always_comb begin
    out_data.wheel_out = w;
    out_data.total_count = tot_r;
    out_data.rpm_avg_q8 = valid_w ? rpm_filt[wr] : 32'd0;
    out_data.distance_q8 = valid_w ? dist_q : 48'd0;
    out_data.last_update_ms = valid_w ? last_update[wr] : 32'd0;
    out_data.stale = !en_w || (elapsed > 32'(stale_limit));
  end
endmodule

/* hdl/wheel_encoder_speed_tracker.sv */
// With a speed update the result follows the rpm division (64 steps), the ring sum
// and the distance division (64 steps); without one, only the distance division.
// One transaction at a time; the next input is taken the cycle after the result is
// taken, so no new item is accepted before the last result is taken.
// Reset (rst, synchronous) clears all wheel state and loads register defaults.
// Result is held until taken.
`timescale 1ns / 1ps
module wheel_encoder_speed_tracker #(
  parameter int NUM_WHEELS   = wes_pkg::NUM_WHEELS_DEF,
  parameter int FILTER_DEPTH = wes_pkg::FILTER_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wes_pkg::CFG_W-1:0]     cfg_data,
  wes_if.sink   in_ch,
  wes_if.source out_ch
);
  import wes_pkg::*;

  wes_cmd_t cmd;
  wes_sts_t sts;

  wes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  wes_dp #(.NUM_WHEELS(NUM_WHEELS), .FILTER_DEPTH(FILTER_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .out_data(out_ch.data)
  );
endmodule

/* tb/sv/tb_wheel_encoder_speed_tracker.sv */
// Testbench for the wheel encoder speed tracker: predicts each result and checks it.
`timescale 1ns / 1ps
module tb_wheel_encoder_speed_tracker;
  import wes_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 160;
  localparam int LONG_HOLD      = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  wes_if #(.T(wes_in_t))  in_ch ();
  wes_if #(.T(wes_out_t)) out_ch ();

  wheel_encoder_speed_tracker dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Shadow copy of the registers and per-wheel tracking state
  logic [3:0]  mask_q;
  logic [15:0] cpr_q, gear_q, circ_q, timeout_q;
  logic [15:0] last_raw [4];
  logic [31:0] count_sum [4];
  logic [31:0] upd_ms [4];
  int          ring [4][4];
  int          ring_pos [4];
  int          speed_avg [4];

  wes_out_t expected_q[$];
  int  n_sent, n_checked, n_errors, n_speed_updates;
  bit  idle_on, hold_req, done;

  // Compute the result of one transaction and advance the shadow state
  function automatic wes_out_t track_wheel(wes_in_t it);
    wes_out_t r;
    int w;
    logic signed [15:0] d16;
    int delta;
    logic [31:0] dt;
    longint num, den, q, sum, cpr_e;
    w = it.wheel;
    cpr_e = (cpr_q == 16'd0) ? 64'sd1 : longint'(cpr_q);
    if (mask_q[w]) begin
      if (it.op) begin
        count_sum[w] = '0;
        last_raw[w] = '0;
      end else begin
        d16 = it.raw_count - last_raw[w];
        delta = d16;
        dt = it.now_ms - upd_ms[w];
        count_sum[w] = count_sum[w] + delta;
        last_raw[w] = it.raw_count;
        if (dt >= MIN_DT_MS) begin
          num = longint'(delta) * MS_PER_MIN * longint'(gear_q);
          den = cpr_e * longint'(dt);
          q = num / den;
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          ring[w][ring_pos[w]] = int'(q);
          ring_pos[w] = (ring_pos[w] + 1) % 4;
          sum = 0;
          for (int k = 0; k < 4; k++) sum += ring[w][k];
          speed_avg[w] = int'(sum / 4);
          upd_ms[w] = it.now_ms;
          n_speed_updates++;
        end
      end
    end
    r.wheel_out      = it.wheel;
    r.total_count    = count_sum[w];
    r.rpm_avg_q8     = speed_avg[w];
    r.distance_q8    = 48'((longint'(signed'(count_sum[w])) * longint'(circ_q)) / cpr_e);
    r.last_update_ms = upd_ms[w];
    r.stale          = !mask_q[w] || ((it.now_ms - upd_ms[w]) > {16'd0, timeout_q});
    return r;
  endfunction

  task automatic report(input string name, input logic [63:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    wes_out_t e;
    wes_out_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        report("wheel_out", e.wheel_out, a.wheel_out);
        report("total_count", e.total_count, a.total_count);
        report("rpm_avg_q8", e.rpm_avg_q8, a.rpm_avg_q8);
        report("distance_q8", e.distance_q8, a.distance_q8);
        report("last_update_ms", e.last_update_ms, a.last_update_ms);
        report("stale", e.stale, a.stale);
        n_checked++;
      end
    end
  end

  // Drive ready: random stall bursts, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("wheel_encoder_speed_tracker test failed");
      $finish;
    end
  end

  task automatic send_item(input wes_in_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(track_wheel(it));
    n_sent++;
  endtask

  task automatic send(input bit op, input int w, input int raw, input logic [31:0] t);
    wes_in_t it;
    it.op = op;
    it.wheel = w[1:0];
    it.raw_count = raw[15:0];
    it.now_ms = t;
    send_item(it);
  endtask

  // Wait until every prediction is matched, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] en, input logic [15:0] cpr, gear, circ, tmo);
    logic [15:0] vals [5];
    vals = '{16'(en), cpr, gear, circ, tmo};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mask_q = en; cpr_q = cpr; gear_q = gear; circ_q = circ; timeout_q = tmo;
  endtask

  // Defaults after reset: wheels 0 and 1 tracked, 2 and 3 disabled
  task automatic test_reset_defaults();
    for (int w = 0; w < 4; w++) send(1'b0, w, 100 * (w + 1), 32'd10);
    send(1'b0, 0, 200, 32'd11);
    send(1'b0, 1, 50, 32'd600);
  endtask

  // Extremes: counter wrap, time wrap, saturation, reset op, short dt
  task automatic test_directed();
    set_regs(4'hF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    send(1'b0, 2, 32767, 32'd2);
    send(1'b0, 2, -32768, 32'd4);
    send(1'b0, 2, 32767, 32'd5);
    send(1'b0, 3, -32768, 32'hFFFF_FFFF);
    send(1'b0, 3, 0, 32'd1);
    send(1'b1, 3, 1234, 32'd9);
    send(1'b0, 3, -1, 32'd20);
    send(1'b1, 0, 0, 32'd0);
    drain();
    set_regs(4'h5, 16'd0, 16'd1, 16'd0, 16'hFFFF);
    send(1'b0, 0, 5, 32'hFFFF_FFF0);
    send(1'b0, 1, 5, 32'd3);
    send(1'b0, 2, -5, 32'd100);
    send(1'b0, 0, 1000, 32'd3);
    drain();
  endtask

  // Random traffic: mostly steady wheel motion, some wild items
  task automatic test_random(input int n);
    logic [31:0] t[4];
    int raw[4];
    int w;
    for (int i = 0; i < 4; i++) begin
      t[i] = $urandom;
      raw[i] = $urandom;
    end
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 3);
      if (i % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        send($urandom_range(0, 1), w, $urandom, $urandom);
      end else begin
        t[w] += $urandom_range(0, 40);
        raw[w] += $urandom_range(0, 600) - 300;
        send($urandom_range(0, 29) == 0, w, raw[w], t[w]);
      end
    end
    drain();
  endtask

  task automatic test_config_sweep();
    set_regs(4'h0, 16'd4096, 16'd512, 16'd1000, 16'd10);
    test_random(40);
    set_regs(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(150);
    set_regs(4'hA, 16'd1, 16'd1, 16'd0, 16'd0);
    test_random(150);
    set_regs($urandom, $urandom_range(1, 65535), $urandom_range(1, 65535), $urandom,
             $urandom_range(0, 200));
    test_random(300);
  endtask

  // Hold the output long enough that the input side stalls
  task automatic test_backpressure();
    set_regs(4'hF, 16'd1440, 16'd256, 16'd5120, 16'd500);
    hold_req = 1;
    test_random(200);
  endtask

  task automatic test_no_idle();
    idle_on = 0;
    set_regs(4'hF, 16'd360, 16'd768, 16'd20000, 16'd50);
    for (int i = 0; i < 600; i++) begin
      if (i == 1) idle_on = 0;
      send($urandom_range(0, 49) == 0, $urandom_range(0, 3), $urandom, i * 3);
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    mask_q = 4'd3; cpr_q = 16'd1440; gear_q = 16'd256; circ_q = 16'd5120;
    timeout_q = 16'd500;
    for (int w = 0; w < 4; w++) begin
      last_raw[w] = '0; count_sum[w] = '0; upd_ms[w] = '0;
      ring_pos[w] = 0; speed_avg[w] = 0;
      for (int k = 0; k < 4; k++) ring[w][k] = 0;
    end
    idle_on = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    drain();
    test_directed();
    test_config_sweep();
    test_backpressure();
    idle_on = 1;
    set_regs(4'hF, 16'd1024, 16'd300, 16'd4000, 16'd30);
    test_random(200);
    test_no_idle();
    done = 1;
    $display("covered %0d items, %0d results checked, %0d speed updates",
             n_sent, n_checked, n_speed_updates);
    $display("register sweeps included extremes, wrap, saturation and a long output hold");
    if (n_errors == 0 && expected_q.size() == 0)
      $display("wheel_encoder_speed_tracker test passed");
    else
      $display("wheel_encoder_speed_tracker test failed");
    $finish;
  end
endmodule
